/* src/lps_pkg.sv */
// Shared types, constants and pattern table for the LED pattern sequencer.
`default_nettype none
package lps_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 16;
  localparam int PERIOD_WIDTH        = 16;
  localparam int CFG_INDEX_WIDTH     = 2;

  localparam logic [PERIOD_WIDTH-1:0] PERIOD_SLOW_RESET = 16'd1000;
  localparam logic [PERIOD_WIDTH-1:0] PERIOD_MID_RESET  = 16'd500;
  localparam logic [PERIOD_WIDTH-1:0] PERIOD_FAST_RESET = 16'd100;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_PERIOD_SLOW = 2'd0,
    REG_PERIOD_MID  = 2'd1,
    REG_PERIOD_FAST = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_FILL        = 2'd0,
    MODE_INTERLEAVED = 2'd1,
    MODE_WALK        = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    SPEED_SLOW = 2'd0,
    SPEED_MID  = 2'd1,
    SPEED_FAST = 2'd2
  } speed_t;

  // Selection codes: bit 0 low half, bit 1 high half
  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_LOW  = 2'd1,
    SEL_HIGH = 2'd2,
    SEL_BOTH = 2'd3
  } sel_t;

  typedef struct packed {
    logic [7:0] leds;
    mode_t      mode;
    speed_t     speed;
  } result_t;

  // Pattern table: mode, selection (low, high, both), step
  localparam logic [7:0] PAT_TAB [0:2][0:2][0:7] = '{
    '{ '{8'h01, 8'h03, 8'h07, 8'h0f, 8'h00, 8'h00, 8'h00, 8'h00},
       '{8'h10, 8'h30, 8'h70, 8'hf0, 8'h00, 8'h00, 8'h00, 8'h00},
       '{8'h01, 8'h03, 8'h07, 8'h0f, 8'h1f, 8'h3f, 8'h7f, 8'hff} },
    '{ '{8'h01, 8'h09, 8'h0b, 8'h0f, 8'h00, 8'h00, 8'h00, 8'h00},
       '{8'h10, 8'h90, 8'hb0, 8'hf0, 8'h00, 8'h00, 8'h00, 8'h00},
       '{8'h01, 8'h11, 8'h13, 8'h33, 8'h37, 8'h77, 8'h7f, 8'hff} },
    '{ '{8'h01, 8'h02, 8'h04, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00},
       '{8'h10, 8'h20, 8'h40, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00},
       '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80} }
  };

endpackage
`default_nettype wire

/* src/led_pattern_sequencer_core.sv */
// Top level of the LED pattern sequencer: configuration registers, handshake, result register.
`default_nettype none
// One input transaction is one millisecond tick carrying the switch and button levels; every
// tick yields exactly one result transaction with the LED pattern, mode and speed in use.
// A tick is taken in every cycle unless the input stalls: the sequencer state updates at
// the input edge, the result is registered at that edge in a single output register, and a
// new tick is accepted whenever that register is empty or being drained in the same cycle.
// Period registers take effect on the next tick; write them only while no tick is in flight.
module led_pattern_sequencer_core #(
  parameter int COUNT_WIDTH = lps_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [lps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [lps_pkg::PERIOD_WIDTH-1:0]   cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               low_half_on,
  input  wire logic                               high_half_on,
  input  wire logic                               mode_button,
  input  wire logic                               speed_button,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [7:0]                              leds,
  output logic [1:0]                              mode_now,
  output logic [1:0]                              speed_now
);
  import lps_pkg::*;

  logic [PERIOD_WIDTH-1:0] period_slow, period_mid, period_fast;
  logic                    in_accept;
  result_t                 result;
  result_t                 out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_slow <= PERIOD_SLOW_RESET;
      period_mid  <= PERIOD_MID_RESET;
      period_fast <= PERIOD_FAST_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PERIOD_SLOW: period_slow <= cfg_data;
        REG_PERIOD_MID:  period_mid  <= cfg_data;
        REG_PERIOD_FAST: period_fast <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold input only while a result waits and the sink stalls
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  lps_ctrl #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .low_half_on  (low_half_on),
    .high_half_on (high_half_on),
    .mode_button  (mode_button),
    .speed_button (speed_button),
    .period_slow  (period_slow),
    .period_mid   (period_mid),
    .period_fast  (period_fast),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_reg <= result;
    end
  end

  assign leds      = out_reg.leds;
  assign mode_now  = out_reg.mode;
  assign speed_now = out_reg.speed;

  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted tick produced no result");

  a_codes_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> mode_now != 2'd3 && speed_now != 2'd3)
    else $error("mode or speed code out of range");

endmodule
`default_nettype wire

/* src/lps_ctrl.sv */
// Sequencer state: button edges, selection tracking, step timing and pattern lookup.
`default_nettype none
module lps_ctrl #(
  parameter int COUNT_WIDTH = lps_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            accept,
  input  wire logic                            low_half_on,
  input  wire logic                            high_half_on,
  input  wire logic                            mode_button,
  input  wire logic                            speed_button,
  input  wire logic [lps_pkg::PERIOD_WIDTH-1:0] period_slow,
  input  wire logic [lps_pkg::PERIOD_WIDTH-1:0] period_mid,
  input  wire logic [lps_pkg::PERIOD_WIDTH-1:0] period_fast,
  output lps_pkg::result_t                     result
);
  import lps_pkg::*;

  localparam int EXT_WIDTH = ((COUNT_WIDTH > PERIOD_WIDTH) ? COUNT_WIDTH : PERIOD_WIDTH) + 1;

  mode_t                  mode_index, mode_index_next;
  speed_t                 speed_index, speed_index_next;
  logic [3:0]             step_index, step_index_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  sel_t                   latched_selection, latched_selection_next;
  logic                   mode_button_prev, speed_button_prev;

  sel_t                   sel;
  logic                   mode_edge, speed_edge;
  logic [3:0]             step_len;
  logic [3:0]             step_cur;
  logic [PERIOD_WIDTH-1:0] period_raw, period_eff;
  logic [EXT_WIDTH-1:0]   tick_inc, period_ext;
  logic                   step_done;
  logic [7:0]             leds_now;

  assign sel        = sel_t'({high_half_on, low_half_on});
  assign mode_edge  = mode_button && !mode_button_prev;
  assign speed_edge = speed_button && !speed_button_prev;
  assign step_len   = (sel == SEL_BOTH) ? 4'd8 : 4'd4;

  always_comb begin
    unique case (speed_index_next)
      SPEED_SLOW: period_raw = period_slow;
      SPEED_MID:  period_raw = period_mid;
      default:    period_raw = period_fast;
    endcase
  end

  // A zero period counts as one tick
  assign period_eff = (period_raw == '0) ? PERIOD_WIDTH'(1) : period_raw;

  always_comb begin
    mode_index_next        = mode_index;
    speed_index_next       = speed_index;
    latched_selection_next = latched_selection;
    step_cur               = step_index;
    tick_count_next        = tick_count;
    if (sel != SEL_NONE) begin
      if (sel != latched_selection) begin
        latched_selection_next = sel;
        step_cur               = '0;
        tick_count_next        = '0;
      end
      if (mode_edge) begin
        mode_index_next = (mode_index == MODE_WALK) ? MODE_FILL : mode_t'(mode_index + 2'd1);
        step_cur        = '0;
        tick_count_next = '0;
      end
      if (speed_edge) begin
        speed_index_next = (speed_index == SPEED_FAST) ? SPEED_SLOW
                                                       : speed_t'(speed_index + 2'd1);
      end
    end else begin
      latched_selection_next = SEL_NONE;
    end
  end

  assign tick_inc   = EXT_WIDTH'(tick_count_next) + EXT_WIDTH'(1);
  assign period_ext = EXT_WIDTH'(period_eff);
  assign step_done  = (tick_inc >= period_ext) || (&tick_count_next);

  always_comb begin
    leds_now = '0;
    if (sel != SEL_NONE && step_cur < step_len && mode_index_next != 2'd3) begin
      leds_now = PAT_TAB[mode_index_next][sel - 2'd1][step_cur[2:0]];
    end
  end

  always_comb begin
    step_index_next = step_cur;
    if (sel == SEL_NONE) begin
      step_index_next = '0;
    end else if (step_done) begin
      step_index_next = (step_cur >= step_len) ? 4'd0 : step_cur + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_index        <= MODE_FILL;
      speed_index       <= SPEED_SLOW;
      step_index        <= '0;
      tick_count        <= '0;
      latched_selection <= SEL_NONE;
      mode_button_prev  <= 1'b0;
      speed_button_prev <= 1'b0;
    end else if (accept) begin
      mode_index        <= mode_index_next;
      speed_index       <= speed_index_next;
      step_index        <= step_index_next;
      latched_selection <= latched_selection_next;
      mode_button_prev  <= mode_button;
      speed_button_prev <= speed_button;
      if (sel == SEL_NONE || step_done) begin
        tick_count <= '0;
      end else begin
        tick_count <= tick_count_next + COUNT_WIDTH'(1);
      end
    end
  end

  assign result.leds  = leds_now;
  assign result.mode  = mode_index_next;
  assign result.speed = speed_index_next;

  a_idle_cleared: assert property (@(posedge clk) disable iff (rst)
    latched_selection == SEL_NONE |-> step_index == '0 && tick_count == '0)
    else $error("step state not cleared with no half selected");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step_index <= 4'd8)
    else $error("step index beyond pattern length");

  a_short_table: assert property (@(posedge clk) disable iff (rst)
    (latched_selection == SEL_LOW || latched_selection == SEL_HIGH) |-> step_index <= 4'd4)
    else $error("step index beyond half pattern length");

endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the LED pattern sequencer core.
`default_nettype none
module tb;
  import lps_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TICK_MAX = (1 << COUNT_WIDTH_DEFAULT) - 1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;

  localparam logic [7:0] WEAVE_HALF [0:3] = '{8'h01, 8'h09, 8'h0b, 8'h0f};
  localparam logic [7:0] WEAVE_BOTH [0:7] =
    '{8'h01, 8'h11, 8'h13, 8'h33, 8'h37, 8'h77, 8'h7f, 8'hff};

  typedef struct packed {
    logic low_on;
    logic high_on;
    logic mode_press;
    logic speed_press;
  } tick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [PERIOD_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic low_half_on = 1'b0;
  logic high_half_on = 1'b0;
  logic mode_button = 1'b0;
  logic speed_button = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] leds;
  logic [1:0] mode_now;
  logic [1:0] speed_now;

  // Predictor state, mirrors the sequencer after reset
  logic [PERIOD_WIDTH-1:0] step_period [0:2] = '{16'd1000, 16'd500, 16'd100};
  mode_t mode_in_use = MODE_FILL;
  speed_t speed_in_use = SPEED_SLOW;
  sel_t held_sel = SEL_NONE;
  int step_at = 0;
  int ticks_in_step = 0;
  logic mode_btn_was = 1'b0;
  logic speed_btn_was = 1'b0;

  tick_t ticks_to_send [$];
  result_t pattern_due [$];

  // Random stimulus keeps switch and button levels between ticks
  logic [1:0] held_switches = 2'b11;
  logic held_mode_btn = 1'b0;
  logic held_speed_btn = 1'b0;

  int send_wait = 0;
  int send_quiet = 0;
  int rcv_wait = 0;
  int rcv_quiet = 0;
  int hold_left = 0;
  int next_hold_at = 150;
  int results_seen = 0;
  int faults = 0;
  int cycles = 0;

  led_pattern_sequencer_core DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .low_half_on(low_half_on),
    .high_half_on(high_half_on),
    .mode_button(mode_button),
    .speed_button(speed_button),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .leds(leds),
    .mode_now(mode_now),
    .speed_now(speed_now)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] pattern_at(input mode_t m, input sel_t s, input int step);
    int v;
    if (step >= ((s == SEL_BOTH) ? 8 : 4)) return 8'h00;
    case (m)
      MODE_FILL: v = (2 << step) - 1;
      MODE_INTERLEAVED: v = (s == SEL_BOTH) ? WEAVE_BOTH[step] : WEAVE_HALF[step];
      default: v = 1 << step;
    endcase
    if (s == SEL_HIGH) v = v << 4;
    return 8'(v);
  endfunction

  function automatic result_t advance_pattern(input tick_t t);
    sel_t s;
    logic m_edge;
    logic s_edge;
    int span;
    int per;
    result_t r;
    s = sel_t'({t.high_on, t.low_on});
    m_edge = t.mode_press && !mode_btn_was;
    s_edge = t.speed_press && !speed_btn_was;
    mode_btn_was = t.mode_press;
    speed_btn_was = t.speed_press;
    r.leds = 8'h00;
    if (s == SEL_NONE) begin
      held_sel = SEL_NONE;
      step_at = 0;
      ticks_in_step = 0;
    end else begin
      span = (s == SEL_BOTH) ? 8 : 4;
      if (s != held_sel) begin
        held_sel = s;
        step_at = 0;
        ticks_in_step = 0;
      end
      if (m_edge) begin
        mode_in_use = (mode_in_use == MODE_WALK) ? MODE_FILL : mode_t'(mode_in_use + 2'd1);
        step_at = 0;
        ticks_in_step = 0;
      end
      if (s_edge)
        speed_in_use = (speed_in_use == SPEED_FAST) ? SPEED_SLOW : speed_t'(speed_in_use + 2'd1);
      r.leds = pattern_at(mode_in_use, s, step_at);
      per = step_period[speed_in_use];
      if (per == 0) per = 1;
      // Speed changes do not restart the step; the new period applies at once
      if (ticks_in_step + 1 >= per || ticks_in_step >= TICK_MAX) begin
        ticks_in_step = 0;
        step_at = (step_at >= span) ? 0 : step_at + 1;
      end else begin
        ticks_in_step++;
      end
    end
    r.mode = mode_in_use;
    r.speed = speed_in_use;
    return r;
  endfunction

  // Mostly no gap, some short, a few long; now and then a quiet stretch
  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet != 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(30, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic add_tick(input logic lo, input logic hi, input logic mb, input logic sb);
    ticks_to_send.push_back('{lo, hi, mb, sb});
  endtask

  task automatic add_random(input int n);
    tick_t t;
    repeat (n) begin
      if ($urandom_range(0, 99) < 8) begin
        t = tick_t'($urandom_range(0, 15));
      end else begin
        if ($urandom_range(0, 24) == 0)
          held_switches = ($urandom_range(0, 4) == 0) ? 2'b00 : 2'($urandom_range(1, 3));
        if ($urandom_range(0, 7) == 0) held_mode_btn = !held_mode_btn;
        if ($urandom_range(0, 9) == 0) held_speed_btn = !held_speed_btn;
        t = '{held_switches[0], held_switches[1], held_mode_btn, held_speed_btn};
      end
      ticks_to_send.push_back(t);
    end
  endtask

  // Wait until every tick is sent and every result is in, then let the block drain
  task automatic settle();
    while (ticks_to_send.size() != 0 || pattern_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_periods(input logic [15:0] slow_p, input logic [15:0] mid_p,
                             input logic [15:0] fast_p, input bit poke_spare);
    cfg_write <= 1'b1;
    cfg_index <= REG_PERIOD_SLOW;
    cfg_data <= slow_p;
    @(posedge clk);
    cfg_index <= REG_PERIOD_MID;
    cfg_data <= mid_p;
    @(posedge clk);
    cfg_index <= REG_PERIOD_FAST;
    cfg_data <= fast_p;
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= REG_SPARE;
      cfg_data <= 16'h0005;
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    step_period[REG_PERIOD_SLOW] = slow_p;
    step_period[REG_PERIOD_MID] = mid_p;
    step_period[REG_PERIOD_FAST] = fast_p;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset periods; no half selected with both buttons pressed is ignored
    add_tick(1, 1, 0, 0);
    add_tick(1, 1, 0, 0);
    add_tick(0, 0, 1, 1);
    add_tick(1, 1, 0, 0);
    settle();

    // One tick per step: walk the full fill table for both halves, the blank step and every mode
    set_periods(16'd1, 16'd1, 16'd1, 1'b0);
    repeat (9) add_tick(1, 1, 0, 0);
    add_tick(1, 1, 1, 0);
    add_tick(1, 1, 1, 0);
    add_tick(1, 1, 0, 0);
    add_tick(1, 1, 1, 0);
    add_tick(1, 1, 0, 1);
    add_tick(1, 0, 0, 0);
    add_tick(1, 0, 0, 0);
    add_tick(0, 1, 0, 0);
    add_tick(0, 1, 0, 0);
    add_tick(1, 0, 1, 0);
    add_tick(0, 0, 0, 0);
    settle();

    set_periods(16'd1, 16'd2, 16'd3, 1'b0);
    add_random(240);
    settle();

    // Zero period, widest period, and a write to an index with no register
    set_periods(16'd0, 16'hffff, 16'd2, 1'b1);
    add_random(240);
    settle();

    set_periods(16'd3, 16'd1, 16'd4, 1'b0);
    add_random(240);
    settle();

    if (faults == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin : driver
    logic busy;
    if (!rst) begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        pattern_due.push_back(advance_pattern(ticks_to_send[0]));
        void'(ticks_to_send.pop_front());
        busy = 1'b0;
        send_wait = pick_gap(send_quiet);
      end
      // Hold a stalled transaction; otherwise offer the next tick or idle
      if (!busy) begin
        if (send_wait != 0 || ticks_to_send.size() == 0) begin
          if (send_wait != 0) send_wait--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          low_half_on <= ticks_to_send[0].low_on;
          high_half_on <= ticks_to_send[0].high_on;
          mode_button <= ticks_to_send[0].mode_press;
          speed_button <= ticks_to_send[0].speed_press;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    logic stall_next;
    if (!rst && out_valid && !out_stall) begin
      if (pattern_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, got leds %h mode %0d speed %0d",
                 $time, leds, mode_now, speed_now);
        faults++;
      end else begin
        want = pattern_due.pop_front();
        if (leds !== want.leds) begin
          $display("%0t: leds expected %h got %h", $time, want.leds, leds);
          faults++;
        end
        if (mode_now !== want.mode) begin
          $display("%0t: mode_now expected %0d got %0d", $time, want.mode, mode_now);
          faults++;
        end
        if (speed_now !== want.speed) begin
          $display("%0t: speed_now expected %0d got %0d", $time, want.speed, speed_now);
          faults++;
        end
        results_seen <= results_seen + 1;
      end
    end
    if (rcv_wait != 0) begin
      rcv_wait--;
      stall_next = 1'b1;
    end else begin
      stall_next = 1'b0;
      rcv_wait = pick_gap(rcv_quiet);
    end
    out_stall <= stall_next || (hold_left != 0);
  end

  // Long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin : hold_off
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (results_seen >= next_hold_at) begin
      hold_left <= 150;
      next_hold_at <= next_hold_at + 410;
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
`default_nettype wire

/* filelist.f */
src/lps_pkg.sv
src/lps_ctrl.sv
src/led_pattern_sequencer_core.sv
tb/tb.sv
